FILE: src/multi_channel_pin_blink_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pin blink sequencer
// Clocked checks with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PIN_BLINK_SEQUENCER_ASSERT_SVH
`define MULTI_CHANNEL_PIN_BLINK_SEQUENCER_ASSERT_SVH

// check that is off while reset is asserted
`define MCPBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check that also holds while reset is asserted
`define MCPBS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: src/mcpbs_pkg.sv
// ----------------------------------------------------------------------------
// Pin blink sequencer package
// Field widths, request codes, engine command type and reload clamp
// ----------------------------------------------------------------------------
package mcpbs_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CH_FIELD_W = 3;
  localparam int unsigned CH_IDX_W   = 4;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned REP_W      = 8;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned PIN_OUT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_PROGRAM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TOGGLE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  typedef struct packed {
    logic                set_pin;
    logic                toggle_pin;
    logic                load;
    logic                step;
    logic [CH_IDX_W-1:0] ch;
    logic                level;
    logic [REP_W-1:0]    reps;
    logic [COUNT_W-1:0]  on_rel;
    logic [COUNT_W-1:0]  off_rel;
  } eng_cmd_t;

  function automatic logic [COUNT_W-1:0] reload_clamp(input logic [MS_W-1:0] quo);
    logic [COUNT_W-1:0] res;
    if (quo == '0) begin
      res = COUNT_W'(1);
    end else if (quo > MS_W'(COUNT_MAX)) begin
      res = COUNT_MAX;
    end else begin
      res = quo[COUNT_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/mcpbs_if.sv
// ----------------------------------------------------------------------------
// Pin blink sequencer channel interfaces
// Request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mcpbs_req_if;
  logic                               valid;
  logic                               ready;
  logic [mcpbs_pkg::REQ_W-1:0]        req_type;
  logic [mcpbs_pkg::CH_FIELD_W-1:0]   channel;
  logic                               first_level;
  logic [mcpbs_pkg::MS_W-1:0]         on_ms;
  logic [mcpbs_pkg::MS_W-1:0]         off_ms;
  logic [mcpbs_pkg::REP_W-1:0]        repeat_count;

  modport source (
    output valid, req_type, channel, first_level, on_ms, off_ms, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel, first_level, on_ms, off_ms, repeat_count,
    output ready
  );
endinterface

interface mcpbs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [mcpbs_pkg::PIN_OUT_W-1:0]    pin_levels;
  logic                               any_active;

  modport source (
    output valid, pin_levels, any_active,
    input  ready
  );
  modport sink (
    input  valid, pin_levels, any_active,
    output ready
  );
endinterface

FILE: src/mcpbs_div.sv
// ----------------------------------------------------------------------------
// Reload divider
// Divide of a millisecond time by the tick length through a reciprocal multiply,
// quotient ready in the cycle after start
// ----------------------------------------------------------------------------
module mcpbs_div #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mcpbs_pkg::MS_W-1:0]         dividend_i,
  output logic                               done_o,
  output logic [mcpbs_pkg::COUNT_W-1:0]      reload_o
);

  localparam int unsigned MS_W    = mcpbs_pkg::MS_W;
  localparam int unsigned RECIP_W = MS_W + 1;
  localparam int unsigned SHIFT   = MS_W + $clog2(TICK_MS);
  localparam int unsigned PROD_W  = MS_W + RECIP_W;
  // ceil(2^SHIFT / TICK_MS) gives the exact quotient for every 16-bit time
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic              done_q;
  logic [MS_W-1:0]   ms_q;
  logic [PROD_W-1:0] prod;
  logic [MS_W-1:0]   quo;

  assign prod = PROD_W'(ms_q) * PROD_W'(RECIP);
  assign quo  = MS_W'(prod >> SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ms_q <= dividend_i;
    end
  end

  assign done_o   = done_q;
  assign reload_o = mcpbs_pkg::reload_clamp(quo);

endmodule

FILE: src/mcpbs_eng.sv
// ----------------------------------------------------------------------------
// Blink engine store
// Per-channel engine state and the shared step unit for one channel a cycle
// ----------------------------------------------------------------------------
module mcpbs_eng #(
  parameter int unsigned CHANNELS = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcpbs_pkg::eng_cmd_t   cmd_i,
  output logic [CHANNELS-1:0]   pins_o,
  output logic                  active_o
);

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned REP_W   = mcpbs_pkg::REP_W;
  localparam int unsigned COUNT_W = mcpbs_pkg::COUNT_W;
  localparam logic [CHANNELS-1:0] PIN_RST = (CHANNELS > 3) ? CHANNELS'(8) : '0;

  logic [CHANNELS-1:0] pins_q;
  logic [CHANNELS-1:0] en_q;
  logic [CHANNELS-1:0] lvl_q;
  logic [REP_W-1:0]    rep_q     [CHANNELS];
  logic [COUNT_W-1:0]  on_rel_q  [CHANNELS];
  logic [COUNT_W-1:0]  off_rel_q [CHANNELS];
  logic [COUNT_W-1:0]  on_cnt_q  [CHANNELS];
  logic [COUNT_W-1:0]  off_cnt_q [CHANNELS];

  logic [CH_W-1:0]    ci;
  logic               en_n;
  logic [REP_W-1:0]   rep_n;
  logic [COUNT_W-1:0] on_n;
  logic [COUNT_W-1:0] off_n;
  logic               pin_we;
  logic               pin_val;
  logic               eng_we;

  assign ci     = cmd_i.ch[CH_W-1:0];
  assign eng_we = cmd_i.load || (cmd_i.step && en_q[ci]);

  always_comb begin
    en_n    = en_q[ci];
    rep_n   = rep_q[ci];
    on_n    = on_cnt_q[ci];
    off_n   = off_cnt_q[ci];
    pin_we  = 1'b0;
    pin_val = 1'b0;
    if (cmd_i.set_pin) begin
      pin_we  = 1'b1;
      pin_val = cmd_i.level;
    end else if (cmd_i.toggle_pin) begin
      pin_we  = 1'b1;
      pin_val = ~pins_q[ci];
    end
    if (cmd_i.load) begin
      en_n  = 1'b1;
      rep_n = cmd_i.reps;
      on_n  = cmd_i.on_rel;
      off_n = cmd_i.off_rel;
    end else if (cmd_i.step && en_q[ci]) begin
      if (rep_q[ci] == '0) begin
        en_n    = 1'b0;
        pin_we  = 1'b1;
        pin_val = ~lvl_q[ci];
      end else if (on_cnt_q[ci] != '0) begin
        on_n = on_cnt_q[ci] - COUNT_W'(1);
        if (on_cnt_q[ci] == COUNT_W'(1)) begin
          pin_we  = 1'b1;
          pin_val = ~lvl_q[ci];
        end
      end else if (off_cnt_q[ci] != '0) begin
        off_n = off_cnt_q[ci] - COUNT_W'(1);
      end else begin
        rep_n = rep_q[ci] - REP_W'(1);
        on_n  = on_rel_q[ci];
        off_n = off_rel_q[ci];
        if (rep_q[ci] != REP_W'(1)) begin
          pin_we  = 1'b1;
          pin_val = lvl_q[ci];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q <= PIN_RST;
      en_q   <= '0;
      lvl_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rep_q[i]     <= '0;
        on_rel_q[i]  <= '0;
        off_rel_q[i] <= '0;
        on_cnt_q[i]  <= '0;
        off_cnt_q[i] <= '0;
      end
    end else begin
      if (pin_we) begin
        pins_q[ci] <= pin_val;
      end
      if (eng_we) begin
        en_q[ci]      <= en_n;
        rep_q[ci]     <= rep_n;
        on_cnt_q[ci]  <= on_n;
        off_cnt_q[ci] <= off_n;
      end
      if (cmd_i.load) begin
        lvl_q[ci]     <= cmd_i.level;
        on_rel_q[ci]  <= cmd_i.on_rel;
        off_rel_q[ci] <= cmd_i.off_rel;
      end
    end
  end

  assign pins_o   = pins_q;
  assign active_o = |en_q;

endmodule

FILE: src/multi_channel_pin_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Multi-channel pin blink sequencer
// Sequencer, reload divider and blink engines behind request/response channels
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one transaction at a time: program, toggle or tick. Every
//   request gives exactly one response transaction on rsp_o with the seven
//   pin levels and the any-active flag, taken after the request is applied.
//   Toggle, program without load and an unused type go straight to the
//   done state; a tick steps through the channels, the step unit visits
//   one channel a cycle; a program with load divides on_ms and then off_ms,
//   which share one multiply, before the load. The next request is taken
//   once the previous one has finished.
//   The response sits in an output register; a stalled receiver does not
//   stop the next request from running, only its response waits until the
//   register is free.
//   Reset clears all engines and drives pin 3 high, other pins low.
// ----------------------------------------------------------------------------
`include "multi_channel_pin_blink_sequencer_assert.svh"

module multi_channel_pin_blink_sequencer #(
  parameter int unsigned CHANNELS = 7,
  parameter int unsigned TICK_MS  = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mcpbs_req_if.sink    req_i,
  mcpbs_rsp_if.source  rsp_o
);

  localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_IDX_W  = mcpbs_pkg::CH_IDX_W;
  localparam int unsigned MS_W      = mcpbs_pkg::MS_W;
  localparam int unsigned REP_W     = mcpbs_pkg::REP_W;
  localparam int unsigned COUNT_W   = mcpbs_pkg::COUNT_W;
  localparam int unsigned PIN_OUT_W = mcpbs_pkg::PIN_OUT_W;
  localparam int unsigned PAD_W     = (CHANNELS > PIN_OUT_W) ? CHANNELS : PIN_OUT_W;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_DIV_ON  = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV_OFF = 3'd2;
  localparam logic [ST_W-1:0] ST_TICK    = 3'd3;
  localparam logic [ST_W-1:0] ST_DONE    = 3'd4;

  logic [ST_W-1:0]     state_q, state_d;
  logic [CH_W-1:0]     idx_q, idx_d;
  logic [COUNT_W-1:0]  on_rel_q, on_rel_d;
  logic [CH_IDX_W-1:0] ch_q;
  logic                lvl_q;
  logic [REP_W-1:0]    reps_q;
  logic [MS_W-1:0]     off_ms_q;
  logic                out_valid_q;
  logic [PIN_OUT_W-1:0] out_pins_q;
  logic                out_any_q;

  logic                accept;
  logic                ch_ok;
  logic                is_load;
  logic                out_load;
  logic                div_start;
  logic [MS_W-1:0]     div_in;
  logic                div_done;
  logic [COUNT_W-1:0]  div_reload;
  mcpbs_pkg::eng_cmd_t cmd;
  logic [CHANNELS-1:0] pins;
  logic                active;
  logic [PAD_W-1:0]    pins_pad;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign ch_ok       = (5'(req_i.channel) < 5'(CHANNELS));
  assign is_load     = (req_i.on_ms != '0) && (req_i.repeat_count != '0);

  mcpbs_div #(
    .TICK_MS (TICK_MS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .reload_o   (div_reload)
  );

  mcpbs_eng #(
    .CHANNELS (CHANNELS)
  ) u_eng (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .pins_o   (pins),
    .active_o (active)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    on_rel_d  = on_rel_q;
    div_start = 1'b0;
    div_in    = req_i.on_ms;
    out_load  = 1'b0;
    cmd       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == mcpbs_pkg::REQ_PROGRAM && ch_ok) begin
            cmd.set_pin = 1'b1;
            cmd.ch      = CH_IDX_W'(req_i.channel);
            cmd.level   = req_i.first_level;
            if (is_load) begin
              div_start = 1'b1;
              state_d   = ST_DIV_ON;
            end else begin
              state_d = ST_DONE;
            end
          end else if (req_i.req_type == mcpbs_pkg::REQ_TOGGLE && ch_ok) begin
            cmd.toggle_pin = 1'b1;
            cmd.ch         = CH_IDX_W'(req_i.channel);
            state_d        = ST_DONE;
          end else if (req_i.req_type == mcpbs_pkg::REQ_TICK) begin
            idx_d   = '0;
            state_d = ST_TICK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV_ON: begin
        if (div_done) begin
          on_rel_d  = div_reload;
          div_start = 1'b1;
          div_in    = off_ms_q;
          state_d   = ST_DIV_OFF;
        end
      end
      ST_DIV_OFF: begin
        if (div_done) begin
          cmd.load    = 1'b1;
          cmd.ch      = ch_q;
          cmd.level   = lvl_q;
          cmd.reps    = reps_q;
          cmd.on_rel  = on_rel_q;
          cmd.off_rel = div_reload;
          state_d     = ST_DONE;
        end
      end
      ST_TICK: begin
        cmd.step = 1'b1;
        cmd.ch   = CH_IDX_W'(idx_q);
        if (idx_q == CH_W'(CHANNELS - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + CH_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pins_pad = PAD_W'(pins);

  always_ff @(posedge clk_i) begin
    on_rel_q <= on_rel_d;
    if (accept) begin
      ch_q     <= CH_IDX_W'(req_i.channel);
      lvl_q    <= req_i.first_level;
      reps_q   <= req_i.repeat_count;
      off_ms_q <= req_i.off_ms;
    end
    if (out_load) begin
      out_pins_q <= pins_pad[PIN_OUT_W-1:0];
      out_any_q  <= active;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.pin_levels = out_pins_q;
  assign rsp_o.any_active = out_any_q;

  `MCPBS_ASSERT(a_busy_after_accept, (req_i.valid && req_i.ready) |=> !req_i.ready, "request taken while busy")
  `MCPBS_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV_ON || state_q == ST_DIV_OFF), "divider done outside divide")
  `MCPBS_ASSERT(a_tick_idx_range, (state_q == ST_TICK) |-> (idx_q <= CH_W'(CHANNELS - 1)), "tick index out of range")
  `MCPBS_ASSERT(a_rsp_from_done, (rsp_o.valid && !$past(rsp_o.valid)) |-> ($past(state_q) == ST_DONE), "response without finished request")
  `MCPBS_ASSERT_RST(a_no_rsp_in_reset, !rst_ni |-> !rsp_o.valid, "response valid in reset")

endmodule

FILE: tb/sv/multi_channel_pin_blink_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pin blink sequencer testbench
// A queue-fed driver sends program, toggle, tick and unused-type
// transactions with random gaps. A monitor mirrors the seven blink engines
// for every accepted request and compares each response with the oldest
// expected pin state. The receiver stalls at random, including two long
// hold-offs that back up the input.
// ----------------------------------------------------------------------------
module multi_channel_pin_blink_sequencer_tb;

  localparam int unsigned REQ_W      = mcpbs_pkg::REQ_W;
  localparam int unsigned CH_FIELD_W = mcpbs_pkg::CH_FIELD_W;
  localparam int unsigned MS_W       = mcpbs_pkg::MS_W;
  localparam int unsigned REP_W      = mcpbs_pkg::REP_W;
  localparam int unsigned COUNT_W    = mcpbs_pkg::COUNT_W;
  localparam int unsigned PIN_OUT_W  = mcpbs_pkg::PIN_OUT_W;

  localparam int unsigned NUM_CH     = 7;
  localparam int unsigned TICK_LEN   = 10;
  localparam int unsigned COUNT_CAP  = (1 << COUNT_W) - 1;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned SETTLE     = 40;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 125;
  localparam int unsigned MAX_GAP    = 18;
  localparam int unsigned SHOW_ERRS  = 10;

  localparam logic [REQ_W-1:0]      REQ_UNUSED = 2'd3;
  localparam logic [CH_FIELD_W-1:0] CH_NONE    = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]      kind;
    logic [CH_FIELD_W-1:0] ch;
    logic                  level;
    logic [MS_W-1:0]       on_ms;
    logic [MS_W-1:0]       off_ms;
    logic [REP_W-1:0]      reps;
  } blink_req_t;

  typedef struct packed {
    logic [PIN_OUT_W-1:0] pins;
    logic                 active;
  } pin_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  mcpbs_req_if req_if ();
  mcpbs_rsp_if rsp_if ();

  multi_channel_pin_blink_sequencer #(
    .CHANNELS (NUM_CH),
    .TICK_MS  (TICK_LEN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine mirror
  logic [NUM_CH-1:0]  pin_mirror;
  logic               eng_on     [NUM_CH];
  logic               eng_level  [NUM_CH];
  logic [REP_W-1:0]   eng_reps   [NUM_CH];
  logic [COUNT_W-1:0] eng_on_rel [NUM_CH];
  logic [COUNT_W-1:0] eng_off_rel[NUM_CH];
  logic [COUNT_W-1:0] eng_on_cnt [NUM_CH];
  logic [COUNT_W-1:0] eng_off_cnt[NUM_CH];

  blink_req_t pending_reqs[$];
  pin_state_t expected_pins[$];

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned resp_cnt     = 0;
  int unsigned n_errors     = 0;
  int unsigned n_loads      = 0;
  int unsigned n_sets       = 0;
  int unsigned n_toggles    = 0;
  int unsigned n_ticks      = 0;
  int unsigned n_ignored    = 0;
  int unsigned n_finished   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rsp_hold     = 0;

  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;

  function automatic logic [COUNT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    int unsigned q;
    q = ms / TICK_LEN;
    if (q == 0) q = 1;
    if (q > COUNT_CAP) q = COUNT_CAP;
    return q[COUNT_W-1:0];
  endfunction

  function automatic void step_engine(input int c);
    if (!eng_on[c]) return;
    if (eng_reps[c] == '0) begin
      pin_mirror[c] = ~eng_level[c];
      eng_on[c]     = 1'b0;
      n_finished++;
    end else if (eng_on_cnt[c] != '0) begin
      eng_on_cnt[c] = eng_on_cnt[c] - COUNT_W'(1);
      if (eng_on_cnt[c] == '0) pin_mirror[c] = ~eng_level[c];
    end else if (eng_off_cnt[c] != '0) begin
      eng_off_cnt[c] = eng_off_cnt[c] - COUNT_W'(1);
    end else begin
      eng_reps[c] = eng_reps[c] - REP_W'(1);
      if (eng_reps[c] != '0) pin_mirror[c] = eng_level[c];
      eng_on_cnt[c]  = eng_on_rel[c];
      eng_off_cnt[c] = eng_off_rel[c];
    end
  endfunction

  function automatic pin_state_t apply_request(input blink_req_t r);
    pin_state_t res;
    int c;
    res.active = 1'b0;
    case (r.kind)
      mcpbs_pkg::REQ_PROGRAM: begin
        if (r.ch < NUM_CH) begin
          pin_mirror[r.ch] = r.level;
          if (r.on_ms != '0 && r.reps != '0) begin
            eng_on[r.ch]      = 1'b1;
            eng_level[r.ch]   = r.level;
            eng_reps[r.ch]    = r.reps;
            eng_on_rel[r.ch]  = ms_to_ticks(r.on_ms);
            eng_off_rel[r.ch] = ms_to_ticks(r.off_ms);
            eng_on_cnt[r.ch]  = eng_on_rel[r.ch];
            eng_off_cnt[r.ch] = eng_off_rel[r.ch];
            n_loads++;
          end else begin
            n_sets++;
          end
        end else begin
          n_ignored++;
        end
      end
      mcpbs_pkg::REQ_TOGGLE: begin
        if (r.ch < NUM_CH) begin
          pin_mirror[r.ch] = ~pin_mirror[r.ch];
          n_toggles++;
        end else begin
          n_ignored++;
        end
      end
      mcpbs_pkg::REQ_TICK: begin
        for (c = 0; c < NUM_CH; c++) step_engine(c);
        n_ticks++;
      end
      default: n_ignored++;
    endcase
    for (c = 0; c < NUM_CH; c++) if (eng_on[c]) res.active = 1'b1;
    res.pins = pin_mirror[PIN_OUT_W-1:0];
    return res;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [CH_FIELD_W-1:0] ch,
                           input logic level, input logic [MS_W-1:0] on_ms,
                           input logic [MS_W-1:0] off_ms, input logic [REP_W-1:0] reps);
    blink_req_t r;
    r.kind   = kind;
    r.ch     = ch;
    r.level  = level;
    r.on_ms  = on_ms;
    r.off_ms = off_ms;
    r.reps   = reps;
    pending_reqs.push_back(r);
    queued_cnt++;
  endtask

  // returns 1 when the block acts on the item
  task automatic queue_random_req(output bit counts);
    int unsigned pick;
    int unsigned sub;
    logic [CH_FIELD_W-1:0] ch;
    pick   = $urandom_range(0, 99);
    sub    = $urandom_range(0, 9);
    ch     = CH_FIELD_W'($urandom_range(0, NUM_CH - 1));
    counts = 1'b1;
    if (pick < 45) begin
      queue_req(mcpbs_pkg::REQ_TICK, CH_FIELD_W'($urandom), 1'($urandom), MS_W'($urandom),
                MS_W'($urandom), REP_W'($urandom));
    end else if (pick < 70) begin
      if (sub == 0) begin
        if ($urandom_range(0, 1))
          queue_req(mcpbs_pkg::REQ_PROGRAM, ch, 1'($urandom), '0, MS_W'($urandom),
                    REP_W'($urandom));
        else
          queue_req(mcpbs_pkg::REQ_PROGRAM, ch, 1'($urandom), MS_W'($urandom),
                    MS_W'($urandom), '0);
      end else if (sub == 1) begin
        queue_req(mcpbs_pkg::REQ_PROGRAM, ch, 1'($urandom), MS_W'($urandom), MS_W'($urandom),
                  REP_W'($urandom));
      end else begin
        queue_req(mcpbs_pkg::REQ_PROGRAM, ch, 1'($urandom), MS_W'($urandom_range(1, 45)),
                  MS_W'($urandom_range(0, 45)), REP_W'($urandom_range(1, 4)));
      end
    end else if (pick < 85) begin
      queue_req(mcpbs_pkg::REQ_TOGGLE, ch, 1'($urandom), MS_W'($urandom), MS_W'($urandom),
                REP_W'($urandom));
    end else if (pick < 92) begin
      queue_req(sub[0] ? mcpbs_pkg::REQ_TOGGLE : mcpbs_pkg::REQ_PROGRAM, CH_NONE,
                1'($urandom), MS_W'($urandom), MS_W'($urandom), REP_W'($urandom));
      counts = 1'b0;
    end else begin
      queue_req(REQ_UNUSED, CH_FIELD_W'($urandom), 1'($urandom), MS_W'($urandom),
                MS_W'($urandom), REP_W'($urandom));
      counts = 1'b0;
    end
  endtask

  task automatic drain;
    while (accepted_cnt != queued_cnt || expected_pins.size() != 0) @(posedge clk_i);
  endtask

  // driver
  int unsigned send_gap  = 0;
  int unsigned send_run  = 0;
  bit          send_calm = 1'b0;

  always @(negedge clk_i) begin
    blink_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!(req_if.valid && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_if.valid        <= 1'b1;
        req_if.req_type     <= nxt.kind;
        req_if.channel      <= nxt.ch;
        req_if.first_level  <= nxt.level;
        req_if.on_ms        <= nxt.on_ms;
        req_if.off_ms       <= nxt.off_ms;
        req_if.repeat_count <= nxt.reps;
        if (send_run == 0) begin
          send_run  = $urandom_range(10, 80);
          send_calm = ($urandom_range(0, 2) == 0);
        end
        send_run--;
        send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  int unsigned recv_wait = 0;
  int unsigned recv_run  = 0;
  bit          recv_calm = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_taken) begin
        if (recv_run == 0) begin
          recv_run  = $urandom_range(10, 80);
          recv_calm = ($urandom_range(0, 2) == 0);
        end
        recv_run--;
        recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: responses first, then the request accepted at this edge
  always @(posedge clk_i) begin
    pin_state_t want;
    blink_req_t got_req;
    if (rst_ni) begin
      rsp_taken <= (rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1);
      req_taken <= (req_if.valid === 1'b1) && (req_if.ready === 1'b1);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        resp_cnt++;
        if (expected_pins.size() == 0) begin
          n_errors++;
          if (n_errors <= SHOW_ERRS)
            $display("%0t: response with no request outstanding: pins %b active %b",
                     $realtime, rsp_if.pin_levels, rsp_if.any_active);
        end else begin
          want = expected_pins.pop_front();
          if (rsp_if.pin_levels !== want.pins || rsp_if.any_active !== want.active) begin
            n_errors++;
            if (n_errors <= SHOW_ERRS)
              $display("%0t: response %0d mismatch: pins exp %b got %b, active exp %b got %b",
                       $realtime, resp_cnt, want.pins, rsp_if.pin_levels, want.active,
                       rsp_if.any_active);
          end
        end
      end
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
        got_req.kind   = req_if.req_type;
        got_req.ch     = req_if.channel;
        got_req.level  = req_if.first_level;
        got_req.on_ms  = req_if.on_ms;
        got_req.off_ms = req_if.off_ms;
        got_req.reps   = req_if.repeat_count;
        expected_pins.push_back(apply_request(got_req));
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned done;
    bit counts;
    int c;
    req_if.valid        = 1'b0;
    req_if.req_type     = mcpbs_pkg::REQ_TICK;
    req_if.channel      = '0;
    req_if.first_level  = 1'b0;
    req_if.on_ms        = '0;
    req_if.off_ms       = '0;
    req_if.repeat_count = '0;
    rsp_if.ready        = 1'b0;
    pin_mirror = NUM_CH'(8);  // pin 3 comes out of reset high
    for (c = 0; c < NUM_CH; c++) begin
      eng_on[c]      = 1'b0;
      eng_level[c]   = 1'b0;
      eng_reps[c]    = '0;
      eng_on_rel[c]  = '0;
      eng_off_rel[c] = '0;
      eng_on_cnt[c]  = '0;
      eng_off_cnt[c] = '0;
    end
    #1 rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    queue_req(mcpbs_pkg::REQ_TOGGLE,  3'd3,    1'b0, '0,      '0,      '0);
    queue_req(REQ_UNUSED,             CH_NONE, 1'b1, '1,      '1,      '1);
    queue_req(mcpbs_pkg::REQ_PROGRAM, CH_NONE, 1'b1, '1,      '1,      '1);
    queue_req(mcpbs_pkg::REQ_TOGGLE,  CH_NONE, 1'b1, '1,      '1,      '1);
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd0,    1'b1, '0,      16'd30,  8'd3);
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd1,    1'b1, 16'd20,  '0,      '0);
    // sub-tick times load the minimum count
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd2,    1'b1, 16'd9,   '0,      8'd1);
    repeat (5) queue_req(mcpbs_pkg::REQ_TICK, 3'd0, 1'b0, '0, '0, '0);
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd6,    1'b0, '1,      '1,      '1);
    // set-only while the engine runs
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd6,    1'b1, '0,      '0,      '0);
    queue_req(mcpbs_pkg::REQ_TICK,    3'd7,    1'b1, '1,      '1,      '1);
    queue_req(mcpbs_pkg::REQ_TOGGLE,  3'd6,    1'b0, '0,      '0,      '0);
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd4,    1'b0, 16'd25,  16'd15,  8'd2);
    repeat (6) queue_req(mcpbs_pkg::REQ_TICK, 3'd0, 1'b0, '0, '0, '0);
    queue_req(mcpbs_pkg::REQ_PROGRAM, 3'd6,    1'b1, 16'd10,  16'd10,  8'd1);
    drain();

    // random phases, each drained before the next
    for (p = 0; p < PHASES; p++) begin
      done = 0;
      while (done < PHASE_LEN) begin
        queue_random_req(counts);
        if (counts) done++;
      end
      if (p == 2 || p == 5) begin
        @(posedge clk_i);
        rsp_hold = (p == 2) ? 500 : 300;
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d transactions: %0d loads, %0d set-only, %0d toggles, %0d ticks",
             accepted_cnt, n_loads, n_sets, n_toggles, n_ticks);
    $display("%0d ignored requests, %0d blink sequences ran to completion",
             n_ignored, n_finished);
    if (n_errors == 0 && expected_pins.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
